@@ hdl/uudecode_decoder_assert.svh @@
`ifndef UUDECODE_DECODER_ASSERT_SVH
`define UUDECODE_DECODER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define UUD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define UUD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/uud_pkg.sv @@
`timescale 1ns / 1ps

package uud_pkg;

    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned QUAD_LEN = 4;
    localparam int unsigned MAX_BYTES = 3;

    localparam logic [1:0] REQ_CHAR  = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_PADDING = 2'd2;

    localparam logic [7:0] PAD_CHAR   = 8'h7E;
    localparam logic [7:0] ZERO_CHAR  = 8'h60;
    localparam logic [7:0] FIRST_CHAR = 8'h21;
    localparam logic [7:0] LAST_CHAR  = 8'h5F;

    typedef struct packed {
        logic                illegal;
        logic [SEXTET_W-1:0] value;
    } t_sextet;

    function automatic t_sextet rev_map(input logic [7:0] ch);
        t_sextet r;
        r.illegal = 1'b1;
        r.value   = '0;
        if (ch == ZERO_CHAR) begin
            r.illegal = 1'b0;
        end else if (ch >= FIRST_CHAR && ch <= LAST_CHAR) begin
            r.illegal = 1'b0;
            r.value   = ch[SEXTET_W-1:0] ^ 6'h20;
        end
        return r;
    endfunction

    function automatic logic [2:0] count_pads(input logic [QUAD_LEN-1:0] marks);
        logic [2:0] n;
        n = '0;
        for (int i = 0; i < QUAD_LEN; i++) begin
            n = n + {2'b00, marks[i]};
        end
        return n;
    endfunction

    function automatic logic [1:0] byte_count(input logic [2:0] pads);
        logic [1:0] n;
        n = (pads >= 3'd3) ? 2'd0 : 2'(3'd3 - pads);
        return n;
    endfunction

endpackage

@@ hdl/uudecode_decoder.sv @@
`timescale 1ns / 1ps
// The first result of a request is valid in the cycle after the request is accepted.
// One request per cycle while no bytes are pending; a request that yields bytes holds the
// output register until all are taken, and the next request can be taken as the last one is.
// Reset: i_rst_n is synchronous, active low; it clears the held quad, pad marks,
// count, end-of-stream flag and the output register.

`include "uudecode_decoder_assert.svh"

module uudecode_decoder
    import uud_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_in
    input  logic [1:0] i_s_tuser,   // [1:0] req_type
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] byte_out
    output logic [1:0] o_m_tuser,   // [1:0] status
    output logic       o_m_tlast    // last
);

    logic [SEXTET_W-1:0] r_sext [QUAD_LEN];
    logic [QUAD_LEN-1:0] r_pads;
    logic [1:0]          r_held;
    logic                r_expect;

    logic [SEXTET_W-1:0] n_sext [QUAD_LEN];
    logic [QUAD_LEN-1:0] n_pads;
    logic [1:0]          n_held;
    logic                n_expect;

    logic                r_busy;
    logic [1:0]          r_left;
    logic [1:0]          r_status;
    logic [7:0]          r_bytes [MAX_BYTES];

    logic [1:0]          n_num;
    logic [1:0]          n_status;
    logic [7:0]          n_bytes [MAX_BYTES];

    logic                s_acc;
    logic                m_acc;
    t_sextet             sx;
    logic [QUAD_LEN-1:0] marks;
    logic [23:0]         quad;
    logic                err;

    assign m_acc      = r_busy && i_m_tready;
    assign o_s_tready = !r_busy || (r_left == 2'd1 && i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = r_bytes[0];
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = (r_left == 2'd1);

    assign sx = rev_map(i_s_tdata);

    always_comb begin
        n_sext   = r_sext;
        n_pads   = r_pads;
        n_held   = r_held;
        n_expect = r_expect;
        n_num    = 2'd0;
        n_status = ST_OK;
        err      = 1'b0;
        marks    = r_pads;
        quad     = {r_sext[0], r_sext[1], r_sext[2], r_sext[3]};
        unique case (i_s_tuser)
            REQ_CLEAR: begin
                n_sext   = '{default: '0};
                n_pads   = '0;
                n_held   = '0;
                n_expect = 1'b0;
            end
            REQ_FLUSH: begin
                if (r_held != 2'd0) begin
                    marks  = r_pads | (4'hF << r_held);
                    n_num  = byte_count(count_pads(marks));
                    n_sext = '{default: '0};
                    n_pads = '0;
                    n_held = '0;
                end
            end
            REQ_CHAR: begin
                if (r_expect) begin
                    err      = 1'b1;
                    n_num    = 2'd1;
                    n_status = ST_PADDING;
                end else if (i_s_tdata == PAD_CHAR) begin
                    n_sext[r_held] = '0;
                    n_pads[r_held] = 1'b1;
                end else if (sx.illegal) begin
                    err      = 1'b1;
                    n_num    = 2'd1;
                    n_status = ST_ILLEGAL;
                    n_sext   = '{default: '0};
                    n_pads   = '0;
                    n_held   = '0;
                end else begin
                    n_sext[r_held] = sx.value;
                end
                if (!err) begin
                    if (r_held == 2'd3) begin
                        quad  = {n_sext[0], n_sext[1], n_sext[2], n_sext[3]};
                        n_num = byte_count(count_pads(n_pads));
                        if (n_pads != '0) begin
                            n_expect = 1'b1;
                        end
                        n_sext = '{default: '0};
                        n_pads = '0;
                        n_held = '0;
                    end else begin
                        n_held = r_held + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        n_bytes[0] = err ? 8'h00 : quad[23:16];
        n_bytes[1] = quad[15:8];
        n_bytes[2] = quad[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sext   <= '{default: '0};
            r_pads   <= '0;
            r_held   <= '0;
            r_expect <= 1'b0;
            r_busy   <= 1'b0;
            r_left   <= '0;
            r_status <= ST_OK;
            r_bytes  <= '{default: '0};
        end else begin
            if (s_acc) begin
                r_sext   <= n_sext;
                r_pads   <= n_pads;
                r_held   <= n_held;
                r_expect <= n_expect;
            end
            if (s_acc && n_num != 2'd0) begin
                r_busy   <= 1'b1;
                r_left   <= n_num;
                r_status <= n_status;
                r_bytes  <= n_bytes;
            end else if (m_acc) begin
                r_bytes[0] <= r_bytes[1];
                r_bytes[1] <= r_bytes[2];
                r_left     <= r_left - 2'd1;
                if (r_left == 2'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    `UUD_ASSERT_NOW(a_err_single, i_clk, i_rst_n, r_busy && r_status != ST_OK, r_left == 2'd1, "error result not single")
    `UUD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != ST_OK, o_m_tdata == 8'h00, "error result carries data")
    `UUD_ASSERT_NEXT(a_clear, i_clk, i_rst_n, s_acc && i_s_tuser == REQ_CLEAR, r_held == 2'd0 && r_pads == '0 && !r_expect && !r_busy, "clear request left state")
    `UUD_ASSERT_NOW(a_pads_held, i_clk, i_rst_n, 1'b1, (r_pads >> r_held) == '0, "pad mark beyond held count")
    `UUD_ASSERT_NOW(a_ready_drain, i_clk, i_rst_n, o_s_tready && r_busy, r_left == 2'd1 && i_m_tready, "request taken while results pending")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import uud_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         ITEM_GOAL  = 460;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SINK_HOLD  = 200;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       is_last;
    } t_decoded;

    class decode_tracker;
        logic [5:0] sextets [4];
        logic [3:0] pad_marks;
        logic [1:0] held;
        bit         ended;
        t_decoded   due [$];
        int         mismatches;

        function new();
            clear_all();
            mismatches = 0;
        endfunction

        function void clear_quad();
            foreach (sextets[i]) sextets[i] = '0;
            pad_marks = '0;
            held      = '0;
        endfunction

        function void clear_all();
            clear_quad();
            ended = 1'b0;
        endfunction

        function void push_bytes(int pads);
            logic [23:0] word;
            t_decoded    r;
            int          nbytes;
            word   = {sextets[0], sextets[1], sextets[2], sextets[3]};
            nbytes = (pads >= 3) ? 0 : 3 - pads;
            for (int k = 0; k < nbytes; k++) begin
                r.data    = word[23 - 8 * k -: 8];
                r.status  = ST_OK;
                r.is_last = (k == nbytes - 1);
                due.push_back(r);
            end
        endfunction

        function void push_error(logic [1:0] code);
            t_decoded r;
            r.data    = '0;
            r.status  = code;
            r.is_last = 1'b1;
            due.push_back(r);
        endfunction

        function void take_request(logic [1:0] req, logic [7:0] ch);
            logic [1:0] pos;
            logic [3:0] marks;
            bit         legal;
            case (req)
                REQ_CLEAR: begin
                    clear_all();
                end
                REQ_FLUSH: begin
                    if (held != 0) begin
                        marks = pad_marks;
                        for (int p = 0; p < 4; p++) begin
                            if (p >= held) marks[p] = 1'b1;
                        end
                        push_bytes($countones(marks));
                        clear_quad();
                    end
                end
                REQ_CHAR: begin
                    if (ended) begin
                        push_error(ST_PADDING);
                    end else begin
                        pos   = held;
                        legal = 1'b1;
                        if (ch == PAD_CHAR) begin
                            sextets[pos]   = '0;
                            pad_marks[pos] = 1'b1;
                        end else if (ch == ZERO_CHAR) begin
                            sextets[pos] = '0;
                        end else if (ch >= FIRST_CHAR && ch <= LAST_CHAR) begin
                            sextets[pos] = 6'(ch - 8'h20);
                        end else begin
                            legal = 1'b0;
                        end
                        if (!legal) begin
                            clear_quad();
                            push_error(ST_ILLEGAL);
                        end else if (pos != 2'd3) begin
                            held = pos + 2'd1;
                        end else begin
                            if (pad_marks != 0) ended = 1'b1;
                            push_bytes($countones(pad_marks));
                            clear_quad();
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        function bit stream_ended();
            return ended;
        endfunction

        function void check_output(logic [7:0] data, logic [1:0] status, logic is_last);
            t_decoded got;
            t_decoded want;
            got.data    = data;
            got.status  = status;
            got.is_last = is_last;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: data %02h status %0d last %0b",
                             data, status, is_last);
                end
            end else begin
                want = due.pop_front();
                if (want !== got) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected data %02h status %0d last %0b,",
                                 want.data, want.status, want.is_last,
                                 " got data %02h status %0d last %0b",
                                 data, status, is_last);
                    end
                end
            end
        endfunction
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = '0;   // [7:0] char_in
    logic [1:0] i_s_tuser  = '0;   // [1:0] req_type
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;         // [7:0] byte_out
    logic [1:0] o_m_tuser;         // [1:0] status
    logic       o_m_tlast;

    decode_tracker tracker = new();
    int            n_items = 0;
    int            cycle_count = 0;
    bit            hold_sink = 1'b0;
    bit            src_steady = 1'b0;
    bit            sink_steady = 1'b0;

    uudecode_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            tracker.check_output(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] legal_char();
        int r;
        r = $urandom_range(0, 63);
        return (r == 0) ? ZERO_CHAR : 8'(8'h20 + r);
    endfunction

    function automatic logic [7:0] illegal_char();
        logic [7:0] ch;
        do begin
            ch = 8'($urandom_range(0, 255));
        end while (ch == PAD_CHAR || ch == ZERO_CHAR || (ch >= FIRST_CHAR && ch <= LAST_CHAR));
        return ch;
    endfunction

    // sink: random stalls, calm stretches, and one long hold on request
    initial begin
        int n;
        forever begin
            if (hold_sink) begin
                hold_sink = 1'b0;
                i_m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge i_clk);
            end
            if ($urandom_range(0, 19) == 0) sink_steady = ~sink_steady;
            n = sink_steady ? 0 : pick_gap();
            if (n > 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    task automatic send_req(logic [1:0] req, logic [7:0] ch);
        int n;
        n = src_steady ? 0 : pick_gap();
        if (n > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.take_request(req, ch);
        if (req != REQ_UNUSED) n_items++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_line();
        int nq;
        int m;
        nq = $urandom_range(1, 4);
        repeat (nq) begin
            repeat (4) send_req(REQ_CHAR, legal_char());
        end
        case ($urandom_range(0, 5))
            1: begin
                m = $urandom_range(1, 3);
                repeat (m) send_req(REQ_CHAR, legal_char());
                send_req(REQ_FLUSH, 8'($urandom_range(0, 255)));
            end
            2: begin
                m = $urandom_range(1, 4);
                repeat (4 - m) send_req(REQ_CHAR, legal_char());
                repeat (m) send_req(REQ_CHAR, PAD_CHAR);
                if ($urandom_range(0, 2) == 0) send_req(REQ_CHAR, legal_char());
            end
            3: begin
                repeat (4) begin
                    send_req(REQ_CHAR, $urandom_range(0, 1) ? PAD_CHAR : legal_char());
                end
            end
            4: begin
                send_req(REQ_CLEAR, 8'($urandom_range(0, 255)));
            end
            5: begin
                m = $urandom_range(0, 3);
                repeat (m) send_req(REQ_CHAR, legal_char());
                send_req(REQ_CHAR, illegal_char());
            end
            default: begin
            end
        endcase
        if (tracker.stream_ended() && $urandom_range(0, 99) < 85) begin
            send_req(REQ_CLEAR, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int line_no;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full quad over the alphabet extremes
        send_req(REQ_CHAR, ZERO_CHAR);
        send_req(REQ_CHAR, FIRST_CHAR);
        send_req(REQ_CHAR, LAST_CHAR);
        send_req(REQ_CHAR, 8'h41);
        // illegal at quad start and inside a quad
        send_req(REQ_CHAR, 8'h20);
        send_req(REQ_CHAR, LAST_CHAR);
        send_req(REQ_CHAR, 8'h7F);
        // all-pad quad, then characters after the padded end
        repeat (4) send_req(REQ_CHAR, PAD_CHAR);
        send_req(REQ_CHAR, 8'h41);
        send_req(REQ_CHAR, PAD_CHAR);
        send_req(REQ_CLEAR, 8'hFF);
        // flush with three held, one a pad
        send_req(REQ_CHAR, 8'h41);
        send_req(REQ_CHAR, 8'h42);
        send_req(REQ_CHAR, PAD_CHAR);
        send_req(REQ_FLUSH, 8'h00);
        send_req(REQ_FLUSH, 8'hFF);
        // flush with one and with two held
        send_req(REQ_CHAR, LAST_CHAR);
        send_req(REQ_FLUSH, 8'h00);
        send_req(REQ_CHAR, 8'h30);
        send_req(REQ_CHAR, 8'h31);
        send_req(REQ_FLUSH, 8'h00);
        send_req(REQ_UNUSED, 8'hFF);
        send_req(REQ_CHAR, 8'h00);
        send_req(REQ_CHAR, 8'hFF);
        drain();

        line_no = 0;
        while (n_items < ITEM_GOAL) begin
            line_no++;
            if ($urandom_range(0, 4) == 0) src_steady = ~src_steady;
            if (line_no == 12) hold_sink = 1'b1;
            if (line_no == 25 || $urandom_range(0, 9) == 0) drain();
            if ($urandom_range(0, 99) < 75) begin
                send_line();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 9))
                        0: send_req(REQ_FLUSH, 8'($urandom_range(0, 255)));
                        1: send_req(REQ_CLEAR, 8'($urandom_range(0, 255)));
                        2: send_req(REQ_UNUSED, 8'($urandom_range(0, 255)));
                        default: send_req(REQ_CHAR, 8'($urandom_range(0, 255)));
                    endcase
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/uud_pkg.sv
hdl/uudecode_decoder.sv
tb/testbench.sv
